// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");
// condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== sv/htp_pkg.sv =====
// ---------------------------------------------------------------------------
// htp_pkg
// Shared types, register indexes and constants of the heading turn PID core.
// ---------------------------------------------------------------------------
`default_nettype none

package htp_pkg;

	localparam int HTP_SUM_WIDTH = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER_MV   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 3'd6;

	localparam logic [15:0] RST_TARGET_HEADING = 16'd0;
	localparam logic [11:0] RST_GAIN_P         = 12'd230;
	localparam logic [11:0] RST_GAIN_I         = 12'd0;
	localparam logic [11:0] RST_GAIN_D         = 12'd64;
	localparam logic [11:0] RST_VELOCITY_GAIN  = 12'd640;
	localparam logic [13:0] RST_MIN_POWER_MV   = 14'd2500;
	localparam logic [11:0] RST_TOLERANCE      = 12'd100;

	localparam logic [15:0] FULL_TURN = 16'd36000;
	localparam logic [14:0] MAX_MV    = 15'd12000;

	typedef struct packed {
		logic [15:0] target_heading;
		logic [11:0] gain_p;
		logic [11:0] gain_i;
		logic [11:0] gain_d;
		logic [11:0] velocity_gain;
		logic [13:0] min_power_mv;
		logic [11:0] tolerance;
	} htp_cfg_t;

	// one step enable per datapath stage, at most one active per cycle
	typedef struct packed {
		logic capture;
		logic err_step;
		logic mul_step;
		logic sum_step;
		logic vmul_step;
		logic scale_step;
		logic load_out;
	} htp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/heading_turn_pid_core.sv =====
// ---------------------------------------------------------------------------
// heading_turn_pid_core
// PID heading controller for a tank drive: one drive command per tick.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one tick word: command, heading
// and the two wheel velocities. command high starts a new turn and clears
// the integral and the previous error before the tick is handled.
// Output channel (out_valid/out_stall) returns one word per tick: the left
// and right drive in millivolts and done_res.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// A word walks a chain of error, product, sum, velocity product, scale and
// output steps, one word at a time; a new word is taken only in the idle
// state, after the previous word has gone to the output register.
// The output register holds a finished word while the next one is in work;
// if it is still stalled when that word is done, the sequencer waits and
// in_stall stays high until the output register frees up.
// Reset clears the sequencer, the integral and previous error, and loads
// the register defaults; out_valid is low after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module heading_turn_pid_core import htp_pkg::*; #(
	parameter int SUM_WIDTH = HTP_SUM_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  command,
	input  wire logic [15:0]           heading,
	input  wire logic signed [7:0]     left_velocity,
	input  wire logic signed [7:0]     right_velocity,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [14:0]         left_drive_mv,
	output logic signed [14:0]         right_drive_mv,
	output logic                       done_res
);

	htp_cfg_t cfg;
	htp_cmd_t cmd;

	htp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	htp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	htp_dp #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.command        (command),
		.heading        (heading),
		.left_velocity  (left_velocity),
		.right_velocity (right_velocity),
		.left_drive_mv  (left_drive_mv),
		.right_drive_mv (right_drive_mv),
		.done_res       (done_res)
	);

	// one word in work at a time
	`ASSERT_AT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
	`ASSERT_AT(a_one_step, $onehot0(cmd))
	`ASSERT_AT(a_done_zero, (out_valid && done_res) |-> (left_drive_mv == 15'sd0 && right_drive_mv == 15'sd0))
	`ASSERT_AT(a_opposite, (out_valid && !done_res) |-> ((left_drive_mv + right_drive_mv) == 15'sd0))
	`ASSERT_NEVER(a_load_while_full, cmd.load_out && out_valid && out_stall)

endmodule

`default_nettype wire

// ===== sv/htp_cfg.sv =====
// ---------------------------------------------------------------------------
// htp_cfg
// Configuration register file, written through a plain enable/index port.
// ---------------------------------------------------------------------------
`default_nettype none

module htp_cfg import htp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output htp_cfg_t                   cfg
);

	htp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_heading <= RST_TARGET_HEADING;
			cfg_q.gain_p         <= RST_GAIN_P;
			cfg_q.gain_i         <= RST_GAIN_I;
			cfg_q.gain_d         <= RST_GAIN_D;
			cfg_q.velocity_gain  <= RST_VELOCITY_GAIN;
			cfg_q.min_power_mv   <= RST_MIN_POWER_MV;
			cfg_q.tolerance      <= RST_TOLERANCE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_HEADING: cfg_q.target_heading <= cfg_data;
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_data[11:0];
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_data[11:0];
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_data[11:0];
				REG_VELOCITY_GAIN:  cfg_q.velocity_gain  <= cfg_data[11:0];
				REG_MIN_POWER_MV:   cfg_q.min_power_mv   <= cfg_data[13:0];
				REG_TOLERANCE:      cfg_q.tolerance      <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/htp_ctrl.sv =====
// ---------------------------------------------------------------------------
// htp_ctrl
// Sequencer: steps one word through the datapath stages and owns the
// input stall and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module htp_ctrl import htp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output htp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ERR   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_VMUL  = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// output register can take a new word when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd            = '0;
		state_d        = state_q;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.err_step   = (state_q == ST_ERR);
		cmd.mul_step   = (state_q == ST_MUL);
		cmd.sum_step   = (state_q == ST_SUM);
		cmd.vmul_step  = (state_q == ST_VMUL);
		cmd.scale_step = (state_q == ST_SCALE);
		cmd.load_out   = (state_q == ST_OUT) && out_free;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ERR;
			ST_ERR:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_VMUL;
			ST_VMUL:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/htp_dp.sv =====
// ---------------------------------------------------------------------------
// htp_dp
// Datapath: turn error and direction, integral and derivative state,
// PID products, velocity correction, millivolt scaling and clamping.
// ---------------------------------------------------------------------------
`default_nettype none

module htp_dp import htp_pkg::*; #(
	parameter int SUM_WIDTH = HTP_SUM_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  htp_cfg_t                cfg,
	input  htp_cmd_t                cmd,
	input  wire logic               command,
	input  wire logic [15:0]        heading,
	input  wire logic signed [7:0]  left_velocity,
	input  wire logic signed [7:0]  right_velocity,
	output logic signed [14:0]      left_drive_mv,
	output logic signed [14:0]      right_drive_mv,
	output logic                    done_res
);

	localparam int S_W  = (SUM_WIDTH + 14 > 42) ? SUM_WIDTH + 14 : 42;
	localparam int PI_W = SUM_WIDTH + 12;

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [S_W-1:0] S_LIMIT = {{(S_W-41){1'b0}}, 1'b1, 40'd0};
	localparam logic [13:0] AVG_SCALE = 14'd12800;
	// drive reaches full scale once m * 3 / 640 reaches 12000
	localparam logic signed [48:0] M_BIG = 49'sd2560000;
	localparam logic [15:0] RECIP5 = 16'd52429;

	function automatic logic [15:0] wrap_angle(input logic [15:0] a);
		return (a >= FULL_TURN) ? a - FULL_TURN : a;
	endfunction

	function automatic logic [7:0] abs8(input logic signed [7:0] v);
		return v[7] ? 8'(-v) : 8'(v);
	endfunction

	// captured word
	logic              cmd_in_q;
	logic [15:0]       head_in_q;
	logic signed [7:0] lv_in_q;
	logic signed [7:0] rv_in_q;

	// controller state
	logic [SUM_WIDTH-1:0] error_sum_q;
	logic [14:0]          last_error_q;

	// error stage
	logic [15:0]          tgt;
	logic [15:0]          head;
	logic signed [16:0]   gap_diff;
	logic [16:0]          gap_abs;
	logic                 done_c;
	logic [16:0]          err_r;
	logic [16:0]          err_l;
	logic                 right_c;
	logic [16:0]          err_w;
	logic [14:0]          err_c;
	logic [SUM_WIDTH-1:0] sum_base;
	logic [14:0]          last_base;
	logic [SUM_WIDTH:0]   sum_add;
	logic [SUM_WIDTH-1:0] sum_sat;
	logic [SUM_WIDTH-1:0] sum_next;
	logic signed [15:0]   deriv_c;
	logic [8:0]           vsum_c;

	logic [14:0]        err_s1;
	logic signed [15:0] deriv_s1;
	logic               right_s1;
	logic               done_s1;
	logic [8:0]         vsum_s1;

	// product stage
	logic [26:0]        pp_c;
	logic [PI_W-1:0]    pi_c;
	logic signed [28:0] pd_c;
	logic [22:0]        avg_c;
	logic [26:0]        pp_s2;
	logic [PI_W-1:0]    pi_s2;
	logic signed [28:0] pd_s2;
	logic [22:0]        avg_s2;

	// sum stage
	logic signed [S_W-1:0] s_full;
	logic signed [S_W-1:0] s_clip;
	logic signed [41:0]    s_c;
	logic signed [42:0]    diff_c;
	logic signed [41:0]    s_s3;
	logic signed [42:0]    diff_s3;

	// velocity gain product
	logic signed [55:0] prod_c;
	logic signed [55:0] prod_s4;

	// scale stage
	logic signed [55:0] prod_adj;
	logic signed [47:0] q8;
	logic signed [48:0] m_c;
	logic [23:0]        m3;
	logic [15:0]        x_s5;
	logic               nonpos_s5;
	logic               big_s5;

	// output stage
	logic [31:0]        qprod;
	logic [14:0]        base_mv;
	logic [14:0]        lo_mv;
	logic [14:0]        mv;
	logic signed [14:0] mv_s;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_in_q  <= command;
			head_in_q <= heading;
			lv_in_q   <= left_velocity;
			rv_in_q   <= right_velocity;
		end
	end

	// shorter way around the circle, leftward wins ties
	always_comb begin
		tgt      = wrap_angle(cfg.target_heading);
		head     = wrap_angle(head_in_q);
		gap_diff = $signed({1'b0, tgt}) - $signed({1'b0, head});
		gap_abs  = gap_diff[16] ? 17'(-gap_diff) : 17'(gap_diff);
		done_c   = gap_abs <= {5'd0, cfg.tolerance};
		err_r    = (tgt < head) ? {1'b0, FULL_TURN} - {1'b0, head} + {1'b0, tgt}
			: {1'b0, tgt} - {1'b0, head};
		err_l    = (tgt > head) ? {1'b0, FULL_TURN} + {1'b0, head} - {1'b0, tgt}
			: {1'b0, head} - {1'b0, tgt};
		right_c  = err_r < err_l;
		err_w    = right_c ? err_r : err_l;
		err_c    = err_w[14:0];

		sum_base  = cmd_in_q ? '0 : error_sum_q;
		last_base = cmd_in_q ? '0 : last_error_q;
		sum_add   = {1'b0, sum_base} + (SUM_WIDTH+1)'(err_c);
		sum_sat   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
		sum_next  = (err_c == 15'd0 || {1'b0, err_c} > tgt) ? '0 : sum_sat;
		deriv_c   = $signed({1'b0, err_c}) - $signed({1'b0, last_base});
		vsum_c    = {1'b0, abs8(lv_in_q)} + {1'b0, abs8(rv_in_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (cmd.err_step) begin
			// a done tick leaves the state as the begin command left it
			if (done_c) begin
				error_sum_q  <= sum_base;
				last_error_q <= last_base;
			end else begin
				error_sum_q  <= sum_next;
				last_error_q <= err_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_step) begin
			err_s1   <= err_c;
			deriv_s1 <= deriv_c;
			right_s1 <= right_c;
			done_s1  <= done_c;
			vsum_s1  <= vsum_c;
		end
	end

	assign pp_c  = cfg.gain_p * err_s1;
	assign pi_c  = cfg.gain_i * error_sum_q;
	assign pd_c  = $signed({1'b0, cfg.gain_d}) * deriv_s1;
	assign avg_c = vsum_s1 * AVG_SCALE;

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			pp_s2  <= pp_c;
			pi_s2  <= pi_c;
			pd_s2  <= pd_c;
			avg_s2 <= avg_c;
		end
	end

	always_comb begin
		s_full = $signed(S_W'(pp_s2)) + $signed(S_W'(pi_s2)) + S_W'(pd_s2);
		s_clip = (s_full > S_LIMIT) ? S_LIMIT : s_full;
		s_c    = s_clip[41:0];
		diff_c = 43'(s_c) - $signed({20'd0, avg_s2});
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_step) begin
			s_s3    <= s_c;
			diff_s3 <= diff_c;
		end
	end

	assign prod_c = diff_s3 * $signed({1'b0, cfg.velocity_gain});

	always_ff @(posedge clk) begin
		if (cmd.vmul_step) begin
			prod_s4 <= prod_c;
		end
	end

	// divide by 256 toward zero, then 3/640 as 3/128 and a divide by five
	always_comb begin
		prod_adj = prod_s4 + (prod_s4[55] ? 56'sd255 : 56'sd0);
		q8       = prod_adj[55:8];
		m_c      = 49'(s_s3) + 49'(q8);
		m3       = 24'(m_c[21:0]) * 24'd3;
	end

	always_ff @(posedge clk) begin
		if (cmd.scale_step) begin
			x_s5      <= m3[22:7];
			nonpos_s5 <= m_c[48] || (m_c == 49'sd0);
			big_s5    <= m_c >= M_BIG;
		end
	end

	always_comb begin
		qprod = x_s5 * RECIP5;
		if (nonpos_s5) begin
			base_mv = '0;
		end else if (big_s5) begin
			base_mv = MAX_MV;
		end else begin
			base_mv = {1'b0, qprod[31:18]};
		end
		lo_mv = (base_mv < {1'b0, cfg.min_power_mv}) ? {1'b0, cfg.min_power_mv} : base_mv;
		mv    = (lo_mv > MAX_MV) ? MAX_MV : lo_mv;
		mv_s  = $signed(mv);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			done_res <= done_s1;
			if (done_s1) begin
				left_drive_mv  <= '0;
				right_drive_mv <= '0;
			end else if (right_s1) begin
				left_drive_mv  <= mv_s;
				right_drive_mv <= -mv_s;
			end else begin
				left_drive_mv  <= -mv_s;
				right_drive_mv <= mv_s;
			end
		end
	end

endmodule

`default_nettype wire
